// File: rtl/core/cnl_pkg.sv
// Package for the column number to letter label converter.
// Holds the shared constants, the queue entry type and the front-end state type.
// No dependencies.
package cnl_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned DIGIT_W    = 5;
    localparam int unsigned MAX_DIGITS = 7;
    localparam int unsigned COUNT_W    = 3;
    localparam int unsigned CHAR_W     = 8;

    localparam logic [4:0]  RADIX      = 5'd26;
    localparam logic [7:0]  MINUS_CHAR = 8'h2D;
    localparam logic [7:0]  UPPER_BASE = 8'h41;
    localparam logic [7:0]  LOWER_BASE = 8'h61;

    // Reciprocal of 13 scaled by 2**35; value / 26 equals ((value >> 1) * RECIP_13) >> 35.
    localparam logic [31:0] RECIP_13   = 32'h9D89_D89E;
    localparam int unsigned RECIP_SHIFT = 35;

    typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_t;

    typedef struct packed {
        logic               negative;
        logic               capitals;
        digits_t            digits;
        logic [COUNT_W-1:0] n_letters;
        logic [COUNT_W-1:0] limit;
    } job_t;

    typedef enum logic {
        FRONT_IDLE,
        FRONT_BUSY
    } front_state_t;

endpackage

// File: rtl/core/cnl_ifs.sv
// Valid/ready channel interfaces for the column label converter.
// Depends on cnl_pkg for the field widths.
interface cnl_column_if;
    logic                                valid;
    logic                                ready;
    logic signed [cnl_pkg::VALUE_W-1:0]  column_value;
    logic                                capitals;

    modport source (output valid, output column_value, output capitals, input ready);
    modport sink (input valid, input column_value, input capitals, output ready);
endinterface

interface cnl_label_if;
    logic                         valid;
    logic                         ready;
    logic [cnl_pkg::CHAR_W-1:0]   out_char;
    logic                         last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink (input valid, input out_char, input last, output ready);
endinterface

// File: rtl/core/cnl_front.sv
// Front end: takes a column number and extracts its base-26 letter digits, one per cycle.
// Depends on cnl_pkg and cnl_ifs; hands finished jobs to the queue when it is not full.
module cnl_front (
    input  logic                          clk,
    input  logic                          rst_n,
    cnl_column_if.sink                    column,
    input  logic [cnl_pkg::COUNT_W-1:0]   max_letters,
    input  logic                          queue_full,
    output logic                          push,
    output cnl_pkg::job_t                 job
);

    cnl_pkg::front_state_t                state_reg, state_next;
    logic [cnl_pkg::VALUE_W-1:0]          value_reg, value_next;
    cnl_pkg::digits_t                     digits_reg, digits_next;
    logic [cnl_pkg::COUNT_W-1:0]          count_reg, count_next;
    logic                                 neg_reg, neg_next;
    logic                                 upper_reg, upper_next;

    logic [30:0]                          half;
    logic [62:0]                          prod;
    logic [cnl_pkg::VALUE_W-1:0]          quot;
    logic [cnl_pkg::VALUE_W-1:0]          quot26;
    logic [cnl_pkg::VALUE_W-1:0]          rem_full;
    logic [cnl_pkg::DIGIT_W-1:0]          digit;
    logic                                 final_step;
    logic [cnl_pkg::COUNT_W-1:0]          n_letters;
    logic [cnl_pkg::COUNT_W-1:0]          eff_max;
    cnl_pkg::digits_t                     digits_out;
    logic                                 accept;
    logic [cnl_pkg::VALUE_W-1:0]          raw;

    always_comb
    begin
        half     = value_reg[31:1];
        prod     = half * cnl_pkg::RECIP_13;
        quot     = 32'(prod >> cnl_pkg::RECIP_SHIFT);
        quot26   = (quot << 4) + (quot << 3) + (quot << 1);
        rem_full = value_reg - quot26;
        digit    = rem_full[cnl_pkg::DIGIT_W-1:0];

        final_step = (quot == '0) ||
                     (count_reg == cnl_pkg::COUNT_W'(cnl_pkg::MAX_DIGITS - 1));
        n_letters  = count_reg + 3'd1;

        digits_out             = digits_reg;
        digits_out[count_reg]  = digit;

        eff_max = (max_letters == '0) ? 3'd1 : max_letters;

        job.negative   = neg_reg;
        job.capitals   = upper_reg;
        job.digits     = digits_out;
        job.n_letters  = n_letters;
        job.limit      = (eff_max > n_letters) ? n_letters : eff_max;

        push         = (state_reg == cnl_pkg::FRONT_BUSY) && final_step && !queue_full;
        column.ready = (state_reg == cnl_pkg::FRONT_IDLE) || push;
        accept       = column.valid && column.ready;
        raw          = column.column_value;

        state_next  = state_reg;
        value_next  = value_reg;
        digits_next = digits_reg;
        count_next  = count_reg;
        neg_next    = neg_reg;
        upper_next  = upper_reg;

        case (state_reg)
            cnl_pkg::FRONT_IDLE:
            begin
                state_next = cnl_pkg::FRONT_IDLE;
            end
            cnl_pkg::FRONT_BUSY:
            begin
                if (push)
                begin
                    state_next = cnl_pkg::FRONT_IDLE;
                end
                else if (!final_step)
                begin
                    value_next  = quot - 32'd1;
                    digits_next = digits_out;
                    count_next  = count_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = cnl_pkg::FRONT_IDLE;
            end
        endcase

        if (accept)
        begin
            state_next = cnl_pkg::FRONT_BUSY;
            neg_next   = raw[31];
            value_next = raw[31] ? (32'd0 - raw) : raw;
            upper_next = column.capitals;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cnl_pkg::FRONT_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        digits_reg <= digits_next;
        count_reg  <= count_next;
        neg_reg    <= neg_next;
        upper_reg  <= upper_next;
    end

    // A 32-bit magnitude never needs more than seven letters.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cnl_pkg::FRONT_BUSY |->
            count_reg < cnl_pkg::COUNT_W'(cnl_pkg::MAX_DIGITS))
        else $error("front digit count overflow");

    a_limit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (job.limit != '0) && (job.limit <= job.n_letters))
        else $error("front produced a bad letter limit");

endmodule

// File: rtl/core/cnl_queue.sv
// Short job queue between the digit extractor and the character serializer.
// Depends on cnl_pkg for the job type.
module cnl_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cnl_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output cnl_pkg::job_t  head,
    output logic           empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cnl_pkg::job_t        entries_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic                 do_push;
    logic                 do_pop;

    always_comb
    begin
        full    = (fill_reg == CNT_W'(DEPTH));
        empty   = (fill_reg == '0);
        head    = entries_reg[rd_ptr_reg];
        do_push = push && !full;
        do_pop  = pop && !empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end

        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");

endmodule

// File: rtl/core/cnl_back.sv
// Back end: walks the job at the queue head and emits one label character per transfer.
// Depends on cnl_pkg and cnl_ifs; the output is registered.
module cnl_back (
    input  logic           clk,
    input  logic           rst_n,
    input  cnl_pkg::job_t  head,
    input  logic           empty,
    output logic           pop,
    cnl_label_if.source    label
);

    logic [cnl_pkg::COUNT_W-1:0]  pos_reg, pos_next;
    logic                         minus_done_reg, minus_done_next;
    logic                         valid_reg, valid_next;
    logic [cnl_pkg::CHAR_W-1:0]   char_reg, char_next;
    logic                         last_reg, last_next;

    logic                         load;
    logic                         emit_minus;
    logic [cnl_pkg::COUNT_W-1:0]  digit_idx;
    logic [cnl_pkg::DIGIT_W-1:0]  digit;
    logic [cnl_pkg::CHAR_W-1:0]   base;
    logic                         final_letter;

    always_comb
    begin
        load         = !empty && (!valid_reg || label.ready);
        emit_minus   = head.negative && !minus_done_reg;
        digit_idx    = head.n_letters - 3'd1 - pos_reg;
        digit        = head.digits[digit_idx];
        base         = head.capitals ? cnl_pkg::UPPER_BASE : cnl_pkg::LOWER_BASE;
        final_letter = (pos_reg == head.limit - 3'd1);

        pos_next        = pos_reg;
        minus_done_next = minus_done_reg;
        char_next       = char_reg;
        last_next       = last_reg;
        pop             = 1'b0;
        valid_next      = label.ready ? 1'b0 : valid_reg;

        if (load)
        begin
            valid_next = 1'b1;
            if (emit_minus)
            begin
                char_next       = cnl_pkg::MINUS_CHAR;
                last_next       = 1'b0;
                minus_done_next = 1'b1;
            end
            else
            begin
                char_next = base + cnl_pkg::CHAR_W'(digit);
                last_next = final_letter;
                if (final_letter)
                begin
                    pop             = 1'b1;
                    pos_next        = '0;
                    minus_done_next = 1'b0;
                end
                else
                begin
                    pos_next = pos_reg + 3'd1;
                end
            end
        end

        label.valid    = valid_reg;
        label.out_char = char_reg;
        label.last     = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            minus_done_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            minus_done_reg <= minus_done_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (char_reg == cnl_pkg::MINUS_CHAR) |-> !last_reg)
        else $error("minus sign flagged as final character");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pos_reg < head.limit)
        else $error("letter position beyond limit");

    a_restart_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (pos_reg == '0) && !minus_done_reg)
        else $error("serializer did not restart after a finished label");

endmodule

// File: rtl/core/column_number_to_letters.sv
// Column number to letter label converter, top level; uses cnl_pkg, cnl_ifs and the front,
// queue and back modules. The front digit extractor finds one to seven letter digits per column
// and takes a new column as it hands its finished job to the queue; the serializer sends one
// character per cycle while label.ready is held high, and the queue lets both work at once.
// Reset clears all control state and sets max_letters to 7; there is no clearing pass.
module column_number_to_letters #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    cnl_column_if.sink                    column,
    cnl_label_if.source                   label,
    input  logic                          max_letters_we,
    input  logic [cnl_pkg::COUNT_W-1:0]   max_letters_wdata
);

    logic [cnl_pkg::COUNT_W-1:0]  max_letters_reg;
    logic                         push;
    logic                         pop;
    logic                         full;
    logic                         empty;
    cnl_pkg::job_t                push_job;
    cnl_pkg::job_t                head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_letters_reg <= 3'd7;
        end
        else if (max_letters_we)
        begin
            max_letters_reg <= max_letters_wdata;
        end
    end

    cnl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .column      (column),
        .max_letters (max_letters_reg),
        .queue_full  (full),
        .push        (push),
        .job         (push_job)
    );

    cnl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    cnl_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .label (label)
    );

endmodule

// File: dv/tb.sv
// Testbench for column_number_to_letters: sends column numbers, predicts each letter label
// and checks every character transfer. Depends on cnl_pkg, cnl_ifs and the RTL top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned ITEMS_PER_PHASE = 51;

    typedef struct packed {
        logic [cnl_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } label_char_t;

    typedef struct packed {
        logic signed [cnl_pkg::VALUE_W-1:0] value;
        logic                               upper;
    } column_req_t;

    logic clk = 1'b0;
    logic rst_n;
    logic max_letters_we;
    logic [cnl_pkg::COUNT_W-1:0] max_letters_wdata;

    cnl_column_if column_ch();
    cnl_label_if label_ch();

    column_number_to_letters i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .column            (column_ch),
        .label             (label_ch),
        .max_letters_we    (max_letters_we),
        .max_letters_wdata (max_letters_wdata)
    );

    column_req_t pending_columns[$];
    label_char_t expected_chars[$];
    logic [cnl_pkg::COUNT_W-1:0] letter_limit;
    bit idling_on;
    bit column_fire;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned quiet_cycles;
    int unsigned columns_queued;
    int unsigned columns_taken;
    int unsigned negatives_taken;
    int unsigned chars_checked;
    int unsigned limits_used;
    int unsigned error_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected characters of one label under the current letter limit.
    function automatic void queue_label(input logic signed [cnl_pkg::VALUE_W-1:0] value,
                                        input logic upper);
        logic [cnl_pkg::VALUE_W-1:0] magnitude;
        longint unsigned rest;
        logic [cnl_pkg::DIGIT_W-1:0] digits [0:7];
        int n_letters;
        int keep;
        logic [cnl_pkg::CHAR_W-1:0] base;
        label_char_t entry;
        magnitude = value[cnl_pkg::VALUE_W-1] ? (32'd0 - 32'(value)) : 32'(value);
        base = upper ? cnl_pkg::UPPER_BASE : cnl_pkg::LOWER_BASE;
        rest = magnitude;
        n_letters = 0;
        while (1'b1)
        begin
            digits[n_letters] = cnl_pkg::DIGIT_W'(rest % cnl_pkg::RADIX);
            n_letters++;
            rest = rest / cnl_pkg::RADIX;
            if (rest == 0 || n_letters >= 8)
                break;
            rest = rest - 1;
        end
        keep = (letter_limit == 0) ? 1 : int'(letter_limit);
        if (keep > n_letters)
            keep = n_letters;
        if (value[cnl_pkg::VALUE_W-1])
        begin
            entry.ch = cnl_pkg::MINUS_CHAR;
            entry.last = 1'b0;
            expected_chars.push_back(entry);
        end
        for (int i = 0; i < keep; i++)
        begin
            entry.ch = base + cnl_pkg::CHAR_W'(digits[n_letters - 1 - i]);
            entry.last = (i == keep - 1);
            expected_chars.push_back(entry);
        end
    endfunction

    function automatic void report_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function automatic void push_column(input logic signed [cnl_pkg::VALUE_W-1:0] value,
                                        input logic upper);
        column_req_t req;
        req.value = value;
        req.upper = upper;
        pending_columns.push_back(req);
        columns_queued++;
    endfunction

    // Mostly labels of a chosen length, with boundary values and raw 32-bit noise.
    function automatic column_req_t random_column();
        column_req_t req;
        int unsigned letters;
        longint unsigned first;
        longint unsigned span;
        longint unsigned mag;
        bit negative;
        first = 0;
        span = cnl_pkg::RADIX;
        letters = $urandom_range(1, 7);
        for (int k = 1; k < letters; k++)
        begin
            first += span;
            span *= cnl_pkg::RADIX;
        end
        negative = $urandom_range(0, 1);
        case ($urandom_range(0, 7))
            0: mag = $urandom();
            1, 2: mag = $urandom_range(0, 1) ? first : first + span - 1;
            default: mag = first + ($urandom() % span);
        endcase
        if (mag > 64'h8000_0000)
            mag = 64'h8000_0000;
        if (!negative && mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        req.value = negative ? (32'd0 - 32'(mag)) : 32'(mag);
        req.upper = $urandom_range(0, 1);
        return req;
    endfunction

    task automatic write_letter_limit(input logic [cnl_pkg::COUNT_W-1:0] value);
        @(negedge clk);
        max_letters_we <= 1'b1;
        max_letters_wdata <= value;
        letter_limit = value;
        limits_used++;
        @(negedge clk);
        max_letters_we <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (columns_taken != columns_queued || expected_chars.size() != 0)
            @(posedge clk);
        repeat (10) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!column_ch.valid || column_fire)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    column_ch.valid <= 1'b0;
                end
                else if (pending_columns.size() > 0)
                begin
                    column_ch.valid <= 1'b1;
                    column_ch.column_value <= pending_columns[0].value;
                    column_ch.capitals <= pending_columns[0].upper;
                    void'(pending_columns.pop_front());
                    if (idling_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 13);
                end
                else
                begin
                    column_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                label_ch.ready <= 1'b0;
            end
            else
            begin
                label_ch.ready <= 1'b1;
                if (idling_on && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 13);
            end
        end
    end

    always @(posedge clk)
    begin
        label_char_t want;
        bit label_fire;
        column_fire = rst_n && column_ch.valid && column_ch.ready;
        label_fire = rst_n && label_ch.valid && label_ch.ready;
        if (column_fire)
        begin
            columns_taken++;
            if (column_ch.column_value[cnl_pkg::VALUE_W-1])
                negatives_taken++;
            queue_label(column_ch.column_value, column_ch.capitals);
        end
        if (label_fire)
        begin
            chars_checked++;
            if (expected_chars.size() == 0)
            begin
                report_failure($sformatf("unexpected character %h last %b",
                                         label_ch.out_char, label_ch.last));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (label_ch.out_char !== want.ch || label_ch.last !== want.last)
                    report_failure($sformatf("expected char %h last %b, got char %h last %b",
                                             want.ch, want.last,
                                             label_ch.out_char, label_ch.last));
            end
        end
        if (rst_n)
        begin
            quiet_cycles = (column_fire || label_fire) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("column_number_to_letters test failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [cnl_pkg::VALUE_W-1:0] directed [0:19];
        logic [cnl_pkg::COUNT_W-1:0] phase_limits [0:7];
        directed = '{32'sd0, 32'sd25, 32'sd26, 32'sd701, 32'sd702, 32'sd18277, 32'sd18278,
                     32'sd475253, 32'sd475254, 32'sd12356629, 32'sd12356630,
                     32'sd321272405, 32'sd321272406, 32'sd2147483647, -32'sd1, -32'sd26,
                     -32'sd702, -32'sd2147483647, 32'h8000_0000, 32'sd1234567};
        phase_limits = '{3'd0, 3'd1, 3'd3, 3'd6, 3'd2, 3'd5, 3'd4, 3'd7};
        rst_n = 1'b0;
        column_ch.valid = 1'b0;
        column_ch.column_value = '0;
        column_ch.capitals = 1'b0;
        label_ch.ready = 1'b0;
        max_letters_we = 1'b0;
        max_letters_wdata = '0;
        letter_limit = 3'd7;
        idling_on = 1'b1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < 20; i++)
            push_column(directed[i], i[0]);
        push_column(32'sd0, 1'b1);
        push_column(32'sd2147483647, 1'b0);
        wait_for_drain();

        for (int p = 0; p < 8; p++)
        begin
            write_letter_limit(phase_limits[p]);
            idling_on = (p != 7) && ($urandom_range(0, 3) != 0);
            if (!idling_on)
            begin
                send_gap = 0;
                stall_left = 0;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                pending_columns.push_back(random_column());
            columns_queued += ITEMS_PER_PHASE;
            wait_for_drain();
        end

        if (expected_chars.size() != 0)
            report_failure($sformatf("%0d characters never arrived", expected_chars.size()));
        $display("Converted %0d columns (%0d negative) into %0d checked characters",
                 columns_taken, negatives_taken, chars_checked);
        $display("under the reset letter limit and %0d written limits; %0d mismatches",
                 limits_used, error_count);
        if (error_count == 0)
            $display("column_number_to_letters test passed");
        else
            $display("column_number_to_letters test failed");
        $finish;
    end
endmodule
